[hw/rtl/pllm_pkg.sv]
package pllm_pkg;

	// default sizing of the node store
	localparam int CAPACITY_DEF    = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// operation codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	// result codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// request word
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
	} in_word_t;

	// response word
	typedef struct packed {
		logic [1:0] status;
		logic [9:0] node_index;
	} out_word_t;

	// memory strobes from the sequencer
	typedef struct packed {
		logic rd_en;
		logic val_we;
		logic link_we;
	} mem_ctl_t;

endpackage

[hw/rtl/pllm_ram.sv]
module pllm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/pllm_ctrl.sv]
module pllm_ctrl #(
	parameter int CAPACITY    = pllm_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = pllm_pkg::VALUE_WIDTH_DEF,
	localparam int IDX_W  = $clog2(CAPACITY),
	localparam int LINK_W = $clog2(CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request side
	input  logic                 req_valid,
	output logic                 req_ready,
	input  pllm_pkg::in_word_t   req,
	// result towards the output register
	output logic                 res_valid,
	input  logic                 res_ready,
	output pllm_pkg::out_word_t  res,
	// node store access
	output pllm_pkg::mem_ctl_t   mem,
	output logic [IDX_W-1:0]     rd_addr,
	output logic [IDX_W-1:0]     wr_addr,
	output logic [VALUE_WIDTH-1:0] val_wdata,
	output logic [LINK_W-1:0]    link_wdata,
	input  logic [VALUE_WIDTH-1:0] val_rdata,
	input  logic [LINK_W-1:0]    link_rdata
);

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
	localparam logic [LINK_W-1:0] LAST_SLOT = LINK_W'(CAPACITY - 1);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_POP    = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_UNLINK = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]             state_q;
	logic [1:0]             kind_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [LINK_W-1:0]      list_head_q;
	logic [LINK_W-1:0]      free_head_q;
	logic [LINK_W-1:0]      handed_q;
	logic [IDX_W-1:0]       cur_q;
	logic [LINK_W-1:0]      prev_q;
	logic [LINK_W-1:0]      steps_q;
	logic [1:0]             status_q;
	logic [9:0]             index_q;

	logic                   free_avail;
	logic                   fresh_avail;
	logic [LINK_W-1:0]      fresh_slot;
	logic [LINK_W-1:0]      nxt_link;
	logic                   hit;
	logic                   walk_end;
	logic signed [63:0]     req_ext;

	// any link outside the store ends a walk
	function automatic logic [LINK_W-1:0] canon_link(input logic [LINK_W-1:0] l);
		canon_link = (l < NULL_LINK) ? l : NULL_LINK;
	endfunction

	assign req_ext     = 64'(req.value);
	assign free_avail  = free_head_q < NULL_LINK;
	assign fresh_avail = handed_q < NULL_LINK;
	assign fresh_slot  = LAST_SLOT - handed_q;
	assign nxt_link    = canon_link(link_rdata);
	assign hit         = val_rdata == val_q;
	assign walk_end    = (nxt_link == NULL_LINK) || (steps_q == LAST_SLOT);

	assign req_ready  = state_q == S_IDLE;
	assign res_valid  = state_q == S_DONE;
	assign res.status     = status_q;
	assign res.node_index = index_q;
	assign val_wdata  = val_q;

	// memory strobes and addresses per state
	always_comb begin
		mem        = '0;
		rd_addr    = list_head_q[IDX_W-1:0];
		wr_addr    = cur_q;
		link_wdata = list_head_q;
		case (state_q)
			S_START: begin
				if (kind_q == pllm_pkg::KIND_INSERT) begin
					if (free_avail) begin
						mem.rd_en = 1'b1;
						rd_addr   = free_head_q[IDX_W-1:0];
					end else if (fresh_avail) begin
						mem.val_we  = 1'b1;
						mem.link_we = 1'b1;
						wr_addr     = fresh_slot[IDX_W-1:0];
					end
				end else if ((kind_q inside {pllm_pkg::KIND_DELETE, pllm_pkg::KIND_SEARCH})
						&& list_head_q != NULL_LINK) begin
					mem.rd_en = 1'b1;
				end
			end
			S_POP: begin
				mem.val_we  = 1'b1;
				mem.link_we = 1'b1;
				wr_addr     = free_head_q[IDX_W-1:0];
			end
			S_WALK: begin
				if (hit) begin
					if (kind_q == pllm_pkg::KIND_DELETE && prev_q != NULL_LINK) begin
						mem.link_we = 1'b1;
						wr_addr     = prev_q[IDX_W-1:0];
						link_wdata  = nxt_link;
					end
				end else if (!walk_end) begin
					mem.rd_en = 1'b1;
					rd_addr   = nxt_link[IDX_W-1:0];
				end
			end
			S_UNLINK: begin
				mem.link_we = 1'b1;
				link_wdata  = free_head_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			list_head_q <= NULL_LINK;
			free_head_q <= NULL_LINK;
			handed_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q  <= req.kind;
						val_q   <= req_ext[VALUE_WIDTH-1:0];
						state_q <= S_START;
					end
				end
				S_START: begin
					status_q <= pllm_pkg::ST_MISS;
					index_q  <= '0;
					state_q  <= S_DONE;
					if (kind_q == pllm_pkg::KIND_INSERT) begin
						if (free_avail) begin
							state_q <= S_POP;
						end else if (fresh_avail) begin
							list_head_q <= fresh_slot;
							handed_q    <= handed_q + 1'b1;
							status_q    <= pllm_pkg::ST_DONE;
							index_q     <= 10'(fresh_slot);
						end else begin
							status_q <= pllm_pkg::ST_FULL;
						end
					end else if ((kind_q inside {pllm_pkg::KIND_DELETE, pllm_pkg::KIND_SEARCH})
							&& list_head_q != NULL_LINK) begin
						cur_q   <= list_head_q[IDX_W-1:0];
						prev_q  <= NULL_LINK;
						steps_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_POP: begin
					free_head_q <= nxt_link;
					list_head_q <= free_head_q;
					status_q    <= pllm_pkg::ST_DONE;
					index_q     <= 10'(free_head_q);
					state_q     <= S_DONE;
				end
				S_WALK: begin
					if (hit) begin
						status_q <= pllm_pkg::ST_DONE;
						if (kind_q == pllm_pkg::KIND_DELETE) begin
							index_q <= '0;
							if (prev_q == NULL_LINK) begin
								list_head_q <= nxt_link;
							end
							state_q <= S_UNLINK;
						end else begin
							index_q <= 10'(cur_q);
							state_q <= S_DONE;
						end
					end else if (walk_end) begin
						status_q <= pllm_pkg::ST_MISS;
						index_q  <= '0;
						state_q  <= S_DONE;
					end else begin
						prev_q  <= LINK_W'(cur_q);
						cur_q   <= nxt_link[IDX_W-1:0];
						steps_q <= steps_q + 1'b1;
					end
				end
				S_UNLINK: begin
					free_head_q <= LINK_W'(cur_q);
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/pooled_linked_list_manager_top.sv]
// Channel | Signals                      | Word fields
// --------+------------------------------+--------------------------
// request | req_valid, req_ready, req    | kind, value
// response| rsp_valid, rsp_ready, rsp    | status, node_index
//
// One request word is handled at a time. An insert goes from acceptance through the start
// step to a loaded response, with a pop step between when a returned slot is reused; delete
// and search walk the list from the head, one node per cycle, since the node store read is
// registered. A delete adds an unlink write after the match. A miss on an empty list or an
// unknown kind goes from the start step straight to the response.
// Reset clears the list heads and slot counter at once; the node store is not cleared.
// A waiting response never blocks completion of the next request beyond its final step.
module pooled_linked_list_manager_top #(
	parameter int CAPACITY    = pllm_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = pllm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  pllm_pkg::in_word_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output pllm_pkg::out_word_t rsp
);

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int LINK_W = $clog2(CAPACITY + 1);

	pllm_pkg::mem_ctl_t  mem;
	pllm_pkg::out_word_t res;
	logic                res_valid;
	logic                res_ready;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    wr_addr;
	logic [VALUE_WIDTH-1:0] val_wdata;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic [LINK_W-1:0]   link_wdata;
	logic [LINK_W-1:0]   link_rdata;
	logic                rsp_valid_q;
	pllm_pkg::out_word_t rsp_q;

	pllm_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem        (mem),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.val_wdata  (val_wdata),
		.link_wdata (link_wdata),
		.val_rdata  (val_rdata),
		.link_rdata (link_rdata)
	);

	// node values
	pllm_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY)
	) u_val_ram (
		.clk   (clk),
		.we    (mem.val_we),
		.waddr (wr_addr),
		.wdata (val_wdata),
		.re    (mem.rd_en),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	// next-slot links, shared by the list and the free list
	pllm_ram #(
		.WIDTH (LINK_W),
		.DEPTH (CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (mem.link_we),
		.waddr (wr_addr),
		.wdata (link_wdata),
		.re    (mem.rd_en),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	// output register
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// only a successful insert or search reports a slot
	a_index_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != pllm_pkg::ST_DONE |-> rsp.node_index == '0)
		else $error("slot index reported with a failing status");

	// a value is never written without its link
	a_value_with_link: assert property (@(posedge clk) disable iff (!arst_n)
		mem.val_we |-> mem.link_we)
		else $error("node value written without its link");

	// one request word in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

	// store is idle while a request may be taken
	a_idle_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !mem.rd_en && !mem.val_we && !mem.link_we)
		else $error("node store accessed while idle");

endmodule

[verif/tb_pooled_linked_list_manager_top.sv]
`timescale 1ns / 1ps

module tb_pooled_linked_list_manager_top;

	localparam int          SLOTS     = pllm_pkg::CAPACITY_DEF;
	localparam logic [10:0] NULL_SLOT = 11'(SLOTS);
	// kind code with no operation behind it
	localparam logic [1:0]  KIND_BAD  = 2'd3;

	// mirror of the node store, the two list heads and the slot counter
	class list_mirror;
		logic signed [31:0]  slot_value [SLOTS];
		logic [10:0]         slot_link [SLOTS];
		logic [10:0]         list_head;
		logic [10:0]         free_head;
		logic [10:0]         slots_handed_out;
		int                  live_count;
		pllm_pkg::out_word_t awaited_rsp [$];
		int                  mismatches;

		function new();
			list_head        = NULL_SLOT;
			free_head        = NULL_SLOT;
			slots_handed_out = '0;
			live_count       = 0;
			mismatches       = 0;
		endfunction

		function bit store_full();
			return free_head == NULL_SLOT && slots_handed_out == 11'(SLOTS);
		endfunction

		// value held by a random node currently on the list
		function logic signed [31:0] live_value();
			logic [10:0] cur;
			int          hops;
			cur  = list_head;
			hops = $urandom_range(0, live_count - 1);
			repeat (hops) cur = slot_link[cur];
			return slot_value[cur];
		endfunction

		// apply one accepted request word and queue the response it causes
		function void apply_request(pllm_pkg::in_word_t w);
			pllm_pkg::out_word_t res;
			logic [10:0]         slot, cur, prev;
			bit                  hit;
			res.status     = pllm_pkg::ST_MISS;
			res.node_index = '0;
			case (w.kind)
				pllm_pkg::KIND_INSERT: begin
					if (free_head != NULL_SLOT) begin
						slot       = free_head;
						free_head  = slot_link[slot];
						res.status = pllm_pkg::ST_DONE;
					end else if (slots_handed_out < 11'(SLOTS)) begin
						slot             = 11'(SLOTS - 1) - slots_handed_out;
						slots_handed_out = slots_handed_out + 11'd1;
						res.status       = pllm_pkg::ST_DONE;
					end else begin
						res.status = pllm_pkg::ST_FULL;
					end
					if (res.status == pllm_pkg::ST_DONE) begin
						slot_value[slot] = w.value;
						slot_link[slot]  = list_head;
						list_head        = slot;
						res.node_index   = slot[9:0];
						live_count++;
					end
				end
				pllm_pkg::KIND_DELETE: begin
					prev = NULL_SLOT;
					cur  = list_head;
					hit  = 1'b0;
					while (cur != NULL_SLOT && !hit) begin
						if (slot_value[cur] == w.value) begin
							hit = 1'b1;
						end else begin
							prev = cur;
							cur  = slot_link[cur];
						end
					end
					if (hit) begin
						if (prev != NULL_SLOT)
							slot_link[prev] = slot_link[cur];
						else
							list_head = slot_link[cur];
						// freed slot goes on top of the free stack
						slot_link[cur] = free_head;
						free_head      = cur;
						res.status     = pllm_pkg::ST_DONE;
						live_count--;
					end
				end
				pllm_pkg::KIND_SEARCH: begin
					cur = list_head;
					hit = 1'b0;
					while (cur != NULL_SLOT && !hit) begin
						if (slot_value[cur] == w.value)
							hit = 1'b1;
						else
							cur = slot_link[cur];
					end
					if (hit) begin
						res.status     = pllm_pkg::ST_DONE;
						res.node_index = cur[9:0];
					end
				end
				default: begin
					// unknown kind: miss, nothing changes
				end
			endcase
			awaited_rsp.push_back(res);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		task check_response(pllm_pkg::out_word_t got);
			pllm_pkg::out_word_t want;
			if (awaited_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d index=%0d",
					got.status, got.node_index));
				return;
			end
			want = awaited_rsp.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.node_index !== want.node_index)
				report_mismatch($sformatf("node_index %0d, want %0d",
					got.node_index, want.node_index));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	pllm_pkg::in_word_t  req;
	logic                rsp_valid;
	logic                rsp_ready;
	pllm_pkg::out_word_t rsp;

	list_mirror mirror;
	int         tx_idle_pct;
	int         rx_idle_pct;

	pooled_linked_list_manager_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// response side: check each accepted word, stall at random
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			mirror.check_response(rsp);
		rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// offer one request word, hold it until taken, then note it
	task automatic send_word(input logic [1:0] kind, input logic signed [31:0] value);
		pllm_pkg::in_word_t w;
		w.kind  = kind;
		w.value = value;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		mirror.apply_request(w);
	endtask

	// operand: often a value on the list, else random, small (duplicates) or extreme
	function automatic logic signed [31:0] pick_value(bit want_live);
		int r;
		if (want_live && mirror.live_count > 0 && $urandom_range(0, 99) < 65)
			return mirror.live_value();
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom;
		if (r < 85)
			return 32'($urandom_range(0, 15)) - 32'sd8;
		case ($urandom_range(0, 3))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	task automatic send_random(input int p_ins, input int p_del, input int p_srch);
		int r;
		r = $urandom_range(0, 99);
		if (r < p_ins)
			send_word(pllm_pkg::KIND_INSERT, pick_value(1'b0));
		else if (r < p_ins + p_del)
			send_word(pllm_pkg::KIND_DELETE, pick_value(1'b1));
		else if (r < p_ins + p_del + p_srch)
			send_word(pllm_pkg::KIND_SEARCH, pick_value(1'b1));
		else
			send_word(KIND_BAD, $urandom);
	endtask

	initial begin
		mirror      = new();
		tx_idle_pct = 32;
		rx_idle_pct = 63;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		rsp_ready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, unknown kind, extremes, duplicates, unlink
		// at head and tail, then reuse of returned slots
		send_word(pllm_pkg::KIND_SEARCH, 32'sd5);
		send_word(pllm_pkg::KIND_DELETE, 32'sd5);
		send_word(KIND_BAD, 32'sd7);
		send_word(pllm_pkg::KIND_INSERT, 32'sh8000_0000);
		send_word(pllm_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
		send_word(pllm_pkg::KIND_INSERT, 32'sd0);
		send_word(pllm_pkg::KIND_INSERT, -32'sd1);
		send_word(pllm_pkg::KIND_INSERT, 32'sh5555_5555);
		send_word(pllm_pkg::KIND_INSERT, 32'shAAAA_AAAA);
		send_word(pllm_pkg::KIND_INSERT, 32'sd0);
		send_word(pllm_pkg::KIND_SEARCH, 32'sd0);
		send_word(pllm_pkg::KIND_SEARCH, 32'sh8000_0000);
		send_word(pllm_pkg::KIND_SEARCH, 32'sh7FFF_FFFF);
		send_word(pllm_pkg::KIND_SEARCH, 32'sd12345);
		send_word(pllm_pkg::KIND_DELETE, 32'sd0);
		send_word(pllm_pkg::KIND_SEARCH, 32'sd0);
		send_word(pllm_pkg::KIND_DELETE, 32'sh8000_0000);
		send_word(pllm_pkg::KIND_DELETE, 32'sh7FFF_FFFF);
		send_word(pllm_pkg::KIND_DELETE, 32'sd99);
		send_word(pllm_pkg::KIND_INSERT, 32'sd42);
		send_word(pllm_pkg::KIND_INSERT, 32'sd43);
		send_word(pllm_pkg::KIND_INSERT, 32'sd44);
		send_word(KIND_BAD, -32'sd1);
		send_word(pllm_pkg::KIND_SEARCH, 32'sd44);

		// random, list growing slowly
		repeat (60) send_random(50, 22, 23);
		tx_idle_pct = 63;
		rx_idle_pct = 32;
		repeat (60) send_random(50, 22, 23);

		// no idling: fill the store, then work around the full state
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (!mirror.store_full()) send_random(94, 3, 2);
		repeat (60) send_random(45, 30, 20);
		req_valid <= 1'b0;

		while (mirror.awaited_rsp.size() > 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (mirror.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hang guard
	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
